[rtl/dps_pkg.sv]
// ----------------------------------------------------------------------------
// Damped pendulum step package
// Shared widths, constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package dps_pkg;

   localparam int FracBits = 16;
   localparam int CordicIters = 30;
   localparam int IterWidth = 5;
   // 2*pi shifted left by this many bits exceeds any angle sum before wrapping.
   localparam int WrapSteps = 13;

   localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
   localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
   localparam logic signed [35:0] GainQ30 = 36'sd652032874;
   localparam logic signed [33:0] PiF = 34'sd205887;
   localparam logic signed [33:0] TwoPiF = 34'sd411774;
   localparam logic signed [31:0] AngleReset = 32'sd655;
   localparam logic signed [31:0] S32Max = 32'sh7FFFFFFF;
   localparam logic signed [31:0] S32Min = 32'sh80000000;

   typedef enum logic [2:0] {
      REG_MASS    = 3'd0,
      REG_LENGTH  = 3'd1,
      REG_GRAVITY = 3'd2,
      REG_INERTIA = 3'd3,
      REG_DAMPING = 3'd4
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_WRAP_FOLD,
      ST_WRAP,
      ST_WRAP_DONE,
      ST_TRIG_SETUP,
      ST_CORDIC,
      ST_TRIG_FIX,
      ST_MUL_UCOS,
      ST_MUL_GSIN,
      ST_SUM_S,
      ST_MUL_ML,
      ST_MUL_MLS,
      ST_MUL_CV,
      ST_MUL_MLL,
      ST_DIV_SETUP,
      ST_DIV,
      ST_DIV_FIX,
      ST_MUL_DTA,
      ST_VEL,
      ST_OUT
   } state_type;

   function automatic logic [31:0] atan_q30(input logic [IterWidth-1:0] i);
      logic [31:0] t;
      case (i)
         5'd0: t = 32'd843314856;  5'd1: t = 32'd497837829;
         5'd2: t = 32'd263043836;  5'd3: t = 32'd133525158;
         5'd4: t = 32'd67021686;   5'd5: t = 32'd33543515;
         5'd6: t = 32'd16775850;   5'd7: t = 32'd8388437;
         5'd8: t = 32'd4194282;    5'd9: t = 32'd2097149;
         5'd10: t = 32'd1048575;   5'd11: t = 32'd524287;
         5'd12: t = 32'd262143;    5'd13: t = 32'd131071;
         5'd14: t = 32'd65535;     5'd15: t = 32'd32767;
         5'd16: t = 32'd16383;     5'd17: t = 32'd8191;
         5'd18: t = 32'd4095;      5'd19: t = 32'd2047;
         5'd20: t = 32'd1023;      5'd21: t = 32'd511;
         5'd22: t = 32'd255;       5'd23: t = 32'd127;
         5'd24: t = 32'd63;        5'd25: t = 32'd31;
         5'd26: t = 32'd15;        5'd27: t = 32'd8;
         5'd28: t = 32'd4;         5'd29: t = 32'd2;
         default: t = 32'd0;
      endcase
      return t;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > 66'sd2147483647) r = S32Max;
      else if (x < -66'sd2147483648) r = S32Min;
      else r = x[31:0];
      return r;
   endfunction

endpackage

[rtl/dps_stream_if.sv]
// ----------------------------------------------------------------------------
// Valid/ready stream channel
// Carries one payload with a valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface dps_stream_if #(parameter int Width = 8);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/dps_mul.sv]
// ----------------------------------------------------------------------------
// Shared multiplier
// Registered signed 33x33 multiply used by every product of the step.
// ----------------------------------------------------------------------------
module dps_mul
   import dps_pkg::*;
(
   input  logic               clock,
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   output logic signed [65:0] product
);
   logic signed [65:0] product_ff;
   logic signed [65:0] product_in;

   assign product_in = op_a * op_b;
   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end
   assign product = product_ff;
endmodule

[rtl/damped_pendulum_step.sv]
// Structure: 13 angle-reduction steps, 30 CORDIC rotations and 64 restoring
// divide steps run between the input transfer and the result becoming valid.
// The input is accepted only while the sequencer is idle, and it stays
// blocked until the pending result transfers.
// Reset: synchronous; state goes to angle 655 and velocity zero, registers
// take their documented defaults.
// ----------------------------------------------------------------------------
// Damped pendulum step
// Semi-implicit Euler pendulum update with CORDIC trig and serial divide.
// ----------------------------------------------------------------------------
module damped_pendulum_step
   import dps_pkg::*;
(
   input  logic clock,
   input  logic reset,
   dps_stream_if.sink   req,
   dps_stream_if.sink   csr,
   dps_stream_if.source rsp
);
   // req.data = {drive_accel, time_step}; csr.data = {index, value}
   // rsp.data = {accel_out, velocity_out, angle_out}
   state_type state_ff, state_in;

   logic [23:0] mass_ff, length_ff, gravity_ff, inertia_ff, damping_ff;
   logic signed [31:0] angle_ff, angle_in, vel_ff, vel_in;
   logic [15:0] dt_ff, dt_in;
   logic signed [31:0] u_ff, u_in;
   logic signed [35:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic flip_ff, flip_in;
   logic [IterWidth:0] cnt_ff, cnt_in;
   logic signed [65:0] acc_ff, acc_in;   // general accumulator
   logic signed [31:0] s_ff, s_in, ml_ff, ml_in, accel_ff, accel_in;
   logic signed [65:0] num_ff, num_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in;
   logic neg_ff, neg_in;
   logic signed [32:0] op_a, op_b;
   logic signed [65:0] product;
   logic rsp_valid_ff, rsp_valid_in;

   dps_mul u_mul (.clock(clock), .op_a(op_a), .op_b(op_b), .product(product));

   logic [2:0] csr_idx;
   assign csr_idx = csr.data[26:24];
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= 24'd32768; length_ff <= 24'd32768; gravity_ff <= 24'd642908;
         inertia_ff <= 24'd3277; damping_ff <= 24'd3277;
      end else if (csr.valid) begin
         case (csr_idx)
            REG_MASS:    mass_ff <= csr.data[23:0];
            REG_LENGTH:  length_ff <= csr.data[23:0];
            REG_GRAVITY: gravity_ff <= csr.data[23:0];
            REG_INERTIA: inertia_ff <= csr.data[23:0];
            REG_DAMPING: damping_ff <= csr.data[23:0];
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = {accel_ff, vel_ff, angle_ff[18:0]};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req.valid && req.ready) state_in = ST_ANGLE;
         ST_ANGLE:      state_in = ST_WRAP_FOLD;
         ST_WRAP_FOLD:  state_in = ST_WRAP;
         ST_WRAP:       if (cnt_ff == 6'd0) state_in = ST_WRAP_DONE;
         ST_WRAP_DONE:  state_in = ST_TRIG_SETUP;
         ST_TRIG_SETUP: state_in = ST_CORDIC;
         ST_CORDIC:     if (cnt_ff == 6'(CordicIters - 1)) state_in = ST_TRIG_FIX;
         ST_TRIG_FIX:   state_in = ST_MUL_UCOS;
         ST_MUL_UCOS:   state_in = ST_MUL_GSIN;
         ST_MUL_GSIN:   state_in = ST_SUM_S;
         ST_SUM_S:      state_in = ST_MUL_ML;
         ST_MUL_ML:     state_in = ST_MUL_MLS;
         ST_MUL_MLS:    state_in = ST_MUL_CV;
         ST_MUL_CV:     state_in = ST_MUL_MLL;
         ST_MUL_MLL:    state_in = ST_DIV_SETUP;
         ST_DIV_SETUP:  state_in = ST_DIV;
         ST_DIV:        if (cnt_ff == 6'd0) state_in = ST_DIV_FIX;
         ST_DIV_FIX:    state_in = ST_MUL_DTA;
         ST_MUL_DTA:    state_in = ST_VEL;
         ST_VEL:        state_in = ST_OUT;
         ST_OUT:        state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath. Products are registered in the multiplier and appear in the next cycle,
   // so each multiply state consumes the product requested by the previous one.
   logic signed [35:0] dx, dy;
   logic [63:0] trial;
   logic [IterWidth-1:0] it;
   logic signed [65:0] wrap_mod;
   assign it = cnt_ff[IterWidth-1:0];
   assign dx = y_ff >>> it;
   assign dy = x_ff >>> it;
   assign trial = {rem_ff[62:0], quo_ff[63]};
   assign wrap_mod = 66'(TwoPiF) << cnt_ff;

   always_comb begin
      angle_in = angle_ff; vel_in = vel_ff; dt_in = dt_ff; u_in = u_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; flip_in = flip_ff; cnt_in = cnt_ff;
      acc_in = acc_ff; s_in = s_ff; ml_in = ml_ff; accel_in = accel_ff;
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff;
      neg_in = neg_ff; rsp_valid_in = rsp_valid_ff;
      op_a = '0; op_b = '0;
      if (rsp.valid && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               dt_in = req.data[15:0];
               u_in = req.data[47:16];
            end
            op_a = 33'(signed'({1'b0, req.data[15:0]}));
            op_b = 33'(vel_ff);
         end
         ST_ANGLE: begin
            acc_in = 66'(angle_ff) + (product >>> 16) + 66'(PiF);
            cnt_in = 6'(WrapSteps - 1);
         end
         ST_WRAP_FOLD: begin
            // Adding a large multiple of 2*pi makes the sum non-negative.
            if (acc_ff < 0) acc_in = acc_ff + (66'(TwoPiF) <<< WrapSteps);
         end
         ST_WRAP: begin
            // Reduce modulo 2*pi by compare and subtract of shifted multiples.
            if (acc_ff >= wrap_mod) acc_in = acc_ff - wrap_mod;
            cnt_in = cnt_ff - 6'd1;
         end
         ST_WRAP_DONE: angle_in = 32'(acc_ff - 66'(PiF));
         ST_TRIG_SETUP: begin
            z_in = 36'(angle_ff) <<< (30 - FracBits);
            flip_in = 1'b0;
            if (z_in > HalfPiQ30) begin z_in = z_in - PiQ30; flip_in = 1'b1; end
            else if (z_in < -HalfPiQ30) begin z_in = z_in + PiQ30; flip_in = 1'b1; end
            x_in = GainQ30; y_in = '0; cnt_in = '0;
         end
         ST_CORDIC: begin
            if (z_ff >= 0) begin
               x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - 36'(atan_q30(it));
            end else begin
               x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + 36'(atan_q30(it));
            end
            cnt_in = cnt_ff + 6'd1;
         end
         ST_TRIG_FIX: begin
            if (flip_ff) begin x_in = -x_ff; y_in = -y_ff; end
            op_a = 33'(u_ff); op_b = 33'(x_in);
         end
         ST_MUL_UCOS: begin
            acc_in = product >>> 30;
            op_a = 33'(signed'({1'b0, gravity_ff})); op_b = 33'(y_ff);
         end
         ST_MUL_GSIN: begin
            acc_in = acc_ff + (product >>> 30);
            op_a = 33'(signed'({1'b0, mass_ff}));
            op_b = 33'(signed'({1'b0, length_ff}));
         end
         ST_SUM_S: begin
            s_in = sat32(acc_ff);
            ml_in = (product[47:FracBits] > 32'h7FFFFFFF) ? S32Max :
                    product[47:FracBits];
         end
         ST_MUL_ML: begin
            op_a = 33'(ml_ff); op_b = 33'(s_ff);
         end
         ST_MUL_MLS: begin
            num_in = product >>> FracBits;
            op_a = 33'(signed'({1'b0, damping_ff})); op_b = 33'(vel_ff);
         end
         ST_MUL_CV: begin
            num_in = num_ff - (product >>> FracBits);
            op_a = 33'(ml_ff); op_b = 33'(signed'({1'b0, length_ff}));
         end
         ST_MUL_MLL: den_in = 64'(inertia_ff) + 64'(product[65:FracBits]);
         ST_DIV_SETUP: begin
            neg_in = num_ff < 0;
            quo_in = 64'(neg_in ? -num_ff : num_ff) << FracBits;
            rem_in = '0;
            cnt_in = 6'd63;
         end
         ST_DIV: begin
            // Restoring division of |num|*2^F by den, one bit per cycle.
            if (trial >= den_ff) begin
               rem_in = trial - den_ff; quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = trial; quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
         end
         ST_DIV_FIX: begin
            if (den_ff == 64'd0)
               accel_in = (num_ff > 0) ? S32Max : ((num_ff < 0) ? S32Min : 32'sd0);
            else if (quo_ff >= 64'h80000000)
               accel_in = neg_ff ? S32Min : S32Max;
            else
               accel_in = neg_ff ? -32'(quo_ff) : 32'(quo_ff);
            op_a = 33'(signed'({1'b0, dt_ff})); op_b = 33'(accel_in);
         end
         ST_MUL_DTA: acc_in = 66'(vel_ff) + (product >>> 16);
         ST_VEL: vel_in = sat32(acc_ff);
         ST_OUT: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         angle_ff <= AngleReset;
         vel_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff <= angle_in;
         vel_ff <= vel_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff <= dt_in; u_ff <= u_in; x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      flip_ff <= flip_in; cnt_ff <= cnt_in; acc_ff <= acc_in; s_ff <= s_in;
      ml_ff <= ml_in; accel_ff <= accel_in; num_ff <= num_in; den_ff <= den_in;
      rem_ff <= rem_in; quo_ff <= quo_in; neg_ff <= neg_in;
   end
endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Damped pendulum step testbench
// Drives pendulum steps and register writes with random gaps and stalls.
// A local fixed-point model predicts angle, velocity and acceleration for
// every accepted step, and each result transfer is checked against it.
// ----------------------------------------------------------------------------
module tb_top
   import dps_pkg::*;
();

   localparam int ReqWidth = 48;
   localparam int RspWidth = 83;
   localparam int CsrWidth = 27;
   localparam logic [2:0] RegBeyondList = 3'd5;
   localparam logic [2:0] RegLastCode = 3'd7;
   localparam longint ModelPiF = 205887;
   localparam longint ModelPiQ30 = 64'sd3373259426;
   localparam longint ModelHalfPiQ30 = 64'sd1686629713;
   localparam longint ModelGain = 64'sd652032874;
   localparam longint Max32 = 64'sd2147483647;
   localparam longint Min32 = -64'sd2147483648;

   typedef struct {
      logic signed [18:0] angle;
      logic signed [31:0] velocity;
      logic signed [31:0] accel;
   } pend_result_type;

   logic clock;
   logic reset;

   dps_stream_if #(.Width(ReqWidth)) req_if ();
   dps_stream_if #(.Width(CsrWidth)) csr_if ();
   dps_stream_if #(.Width(RspWidth)) rsp_if ();

   damped_pendulum_step u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .csr   (csr_if.sink),
      .rsp   (rsp_if.source)
   );

   // Local copy of the pendulum state and registers.
   longint unsigned mdl_mass, mdl_length, mdl_gravity, mdl_inertia, mdl_damping;
   longint mdl_angle, mdl_velocity;

   pend_result_type expected_results[$];
   int mismatches = 0;
   int results_seen = 0;
   int steps_sent = 0;
   int writes_done = 0;
   int stall_left = 0;

   longint atan_tab[30] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
      127, 63, 31, 15, 8, 4, 2};

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic longint clip32(input longint x);
      if (x > Max32) return Max32;
      if (x < Min32) return Min32;
      return x;
   endfunction

   function automatic longint quotient_q16(input longint num, input longint den);
      longint unsigned mag, q, r, res;
      bit neg;
      neg = num < 0;
      mag = neg ? -num : num;
      if (den <= 0) return num > 0 ? Max32 : (num < 0 ? Min32 : 0);
      q = mag / den;
      r = mag % den;
      if (q >= (64'd1 << 15)) return neg ? Min32 : Max32;
      res = (q << 16) + (r << 16) / den;
      return neg ? -longint'(res) : longint'(res);
   endfunction

   function automatic pend_result_type predict_step(input logic [15:0] dt_in,
                                                    input logic signed [31:0] u_in);
      pend_result_type r;
      longint dt, u, m, x, y, z, dx, dy, s, ml, num, den, acc;
      longint unsigned mlu;
      bit flip;
      dt = dt_in;
      u = u_in;
      // Advance the angle with the old velocity, then wrap to [-pi, pi).
      m = (mdl_angle + ((dt * mdl_velocity) >>> 16) + ModelPiF) % (2 * ModelPiF);
      if (m < 0) m += 2 * ModelPiF;
      mdl_angle = m - ModelPiF;
      z = mdl_angle <<< 14;
      x = ModelGain;
      y = 0;
      flip = 0;
      if (z > ModelHalfPiQ30) begin
         z -= ModelPiQ30;
         flip = 1;
      end else if (z < -ModelHalfPiQ30) begin
         z += ModelPiQ30;
         flip = 1;
      end
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      s = clip32(((u * x) >>> 30) + ((longint'(mdl_gravity) * y) >>> 30));
      mlu = (mdl_mass * mdl_length) >> 16;
      ml = mlu > Max32 ? Max32 : longint'(mlu);
      num = ((ml * s) >>> 16) - ((longint'(mdl_damping) * mdl_velocity) >>> 16);
      den = longint'(mdl_inertia) + longint'((longint'(ml) * mdl_length) >> 16);
      acc = quotient_q16(num, den);
      mdl_velocity = clip32(mdl_velocity + ((dt * acc) >>> 16));
      r.angle = mdl_angle[18:0];
      r.velocity = mdl_velocity[31:0];
      r.accel = acc[31:0];
      return r;
   endfunction

   // Sends one step; the caller is at a falling edge.
   task automatic send_step(input logic [15:0] dt, input logic signed [31:0] u);
      req_if.valid = 1'b1;
      req_if.data = {u, dt};
      do @(posedge clock); while (!req_if.ready);
      expected_results = {expected_results, predict_step(dt, u)};
      steps_sent++;
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      repeat (n) @(negedge clock);
   endtask

   task automatic drain_results();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (90) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
      csr_if.valid = 1'b1;
      csr_if.data = {idx, value};
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         REG_MASS:    mdl_mass = value;
         REG_LENGTH:  mdl_length = value;
         REG_GRAVITY: mdl_gravity = value;
         REG_INERTIA: mdl_inertia = value;
         REG_DAMPING: mdl_damping = value;
         default: ;
      endcase
      writes_done++;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic write_all(input logic [23:0] m, input logic [23:0] l,
                            input logic [23:0] g, input logic [23:0] j,
                            input logic [23:0] c);
      write_reg(REG_MASS, m);
      write_reg(REG_LENGTH, l);
      write_reg(REG_GRAVITY, g);
      write_reg(REG_INERTIA, j);
      write_reg(REG_DAMPING, c);
   endtask

   task automatic test_defaults();
      send_step(16'd655, 32'sd0);
      send_step(16'd0, 32'sd0);
      send_step(16'hFFFF, 32'sh7FFFFFFF);
      send_step(16'hFFFF, 32'sh80000000);
      send_step(16'h8000, -32'sd1);
      send_step(16'd1, 32'sd1);
      drain_results();
   endtask

   task automatic test_zero_denominator();
      // Inertia and mass zero: the divider sees a zero denominator.
      write_all(24'd0, 24'd32768, 24'd642908, 24'd0, 24'd3277);
      send_step(16'h4000, 32'sd0);
      send_step(16'hFFFF, 32'sd100000);
      send_step(16'hFFFF, -32'sd100000);
      drain_results();
      write_all(24'd65536, 24'd0, 24'd0, 24'd0, 24'd0);
      send_step(16'h1000, 32'sd0);
      send_step(16'hFFFF, 32'sd50000);
      drain_results();
   endtask

   task automatic test_overflow();
      // Full-scale registers push the quotient and the velocity to saturation.
      write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'hFFFFFF);
      send_step(16'hFFFF, 32'sh7FFFFFFF);
      send_step(16'hFFFF, 32'sh80000000);
      drain_results();
      write_all(24'd1, 24'd1, 24'hFFFFFF, 24'd1, 24'd0);
      send_step(16'hFFFF, 32'sh7FFFFFFF);
      send_step(16'hFFFF, 32'sh7FFFFFFF);
      send_step(16'hFFFF, 32'sh80000000);
      drain_results();
   endtask

   task automatic test_unused_index();
      write_all(24'd32768, 24'd32768, 24'd642908, 24'd3277, 24'd3277);
      for (logic [3:0] i = RegBeyondList; i <= RegLastCode; i++)
         write_reg(i[2:0], 24'hFFFFFF);
      send_step(16'd655, 32'sd65536);
      send_step(16'd655, -32'sd65536);
      drain_results();
   endtask

   task automatic test_backpressure();
      // Receiver holds off while steps keep coming, so the input stalls.
      stall_left = 500;
      repeat (8) send_step(16'($urandom_range(0, 2000)),
                           32'($urandom_range(0, 200000) - 100000));
      drain_results();
   endtask

   task automatic random_config();
      logic [23:0] v[5];
      for (int k = 0; k < 5; k++) begin
         case ($urandom_range(0, 5))
            0: v[k] = 24'd0;
            1: v[k] = 24'hFFFFFF;
            2: v[k] = 24'($urandom());
            default: v[k] = 24'($urandom_range(1000, 200000));
         endcase
      end
      write_all(v[0], v[1], v[2], v[3], v[4]);
   endtask

   task automatic test_random(input int count);
      logic [15:0] dt;
      logic signed [31:0] u;
      for (int p = 0; p < 5; p++) begin
         random_config();
         for (int n = 0; n < count / 5; n++) begin
            dt = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1500));
            case ($urandom_range(0, 5))
               0: u = $urandom();
               1: u = 32'sd0;
               default: u = $signed($urandom_range(0, 400000)) - 32'sd200000;
            endcase
            send_step(dt, u);
            idle_gap();
         end
         drain_results();
      end
   endtask

   // Result side: random ready with occasional long stalls.
   initial begin
      int n;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else begin
            n = $urandom_range(0, 19);
            rsp_if.ready = (n < 14) ? 1'b1 : 1'b0;
            if (n == 19) stall_left = $urandom_range(20, 120);
         end
      end
   end

   always @(posedge clock) begin
      pend_result_type want;
      logic signed [18:0] got_angle;
      logic signed [31:0] got_vel, got_acc;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         {got_acc, got_vel, got_angle} = rsp_if.data;
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: angle %0d vel %0d acc %0d",
                        got_angle, got_vel, got_acc);
         end else begin
            want = expected_results.pop_front();
            if (got_angle !== want.angle || got_vel !== want.velocity ||
                got_acc !== want.accel) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected angle %0d vel %0d acc %0d, got %0d %0d %0d",
                           results_seen, want.angle, want.velocity, want.accel,
                           got_angle, got_vel, got_acc);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("timeout after %0d steps and %0d results", steps_sent, results_seen);
      $display("status: fail");
      $finish;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      reset = 1'b1;
      mdl_mass = 32768;
      mdl_length = 32768;
      mdl_gravity = 642908;
      mdl_inertia = 3277;
      mdl_damping = 3277;
      mdl_angle = 655;
      mdl_velocity = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_defaults();
      test_zero_denominator();
      test_overflow();
      test_unused_index();
      test_backpressure();
      test_random(1250);
      drain_results();
      $display("covered %0d steps and %0d register writes, %0d results checked",
               steps_sent, writes_done, results_seen);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches,
                  expected_results.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule

[damped_pendulum_step.f]
rtl/dps_pkg.sv
rtl/dps_stream_if.sv
rtl/dps_mul.sv
rtl/damped_pendulum_step.sv
verif/tb_top.sv
